// File: rtl/av1sw_pkg.sv
// ---------------------------------------------------------------------------
// av1sw_pkg
// Shared types and constants for the AV1 syntax-element bit writer.
// ---------------------------------------------------------------------------
package av1sw_pkg;

   // Field widths
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned SIZE_W  = 32;
   localparam int unsigned LEN_W   = 7;    // bit length of one packet, 0..64
   localparam int unsigned ACC_W   = 72;   // holds up to 71 pending bits
   localparam int unsigned CNT_W   = 7;    // pending bit count, 0..71

   // Request operation codes
   typedef enum logic [2:0] {
      ACT_F       = 3'd0,
      ACT_UVLC    = 3'd1,
      ACT_NS      = 3'd2,
      ACT_SU      = 3'd3,
      ACT_LE      = 3'd4,
      ACT_ALIGN   = 3'd5,
      ACT_TRAIL   = 3'd6,
      ACT_RESTART = 3'd7
   } act_type;

   // Kind of work handed from front end to back end
   typedef enum logic [1:0] {
      PKT_BITS    = 2'd0,
      PKT_ERROR   = 2'd1,
      PKT_RESTART = 2'd2
   } pkt_kind_type;

   // One queued work packet: bits are left aligned, low bits below len are zero
   typedef struct packed {
      pkt_kind_type         kind;
      logic [LEN_W-1:0]     len;
      logic [VALUE_W-1:0]   bits;
   } pkt_type;

endpackage

// File: rtl/av1_syntax_element_bit_writer.sv
// ---------------------------------------------------------------------------
// av1_syntax_element_bit_writer
// Packs AV1 syntax elements (f, uvlc, ns, su, le, byte align, trailing bits)
// MSB first into bytes and reports argument errors.
// ---------------------------------------------------------------------------
// A request is taken in every cycle while the packet queue (QUEUE_DEPTH
// entries) has room. The back end emits one result per cycle unless the
// output stalls, so a request that completes k bytes (k = 0..8) occupies it
// for k results; requests that complete at most one byte sustain one request
// per cycle unless the output stalls. Results pass through the queue and the
// output register. An error result (status 1, byte 0, last set) is sent for
// a bad argument, after which every request but restart is dropped until a
// restart request arrives. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module av1_syntax_element_bit_writer
   import av1sw_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_action,
   input  logic [VALUE_W-1:0]   req_value,
   input  logic [SIZE_W-1:0]    req_size_arg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_item,
   output logic                 rsp_status
);

   logic      q_full;
   logic      q_empty;
   logic      q_push;
   logic      q_pop;
   pkt_type   q_in_pkt;
   pkt_type   q_out_pkt;

   assign req_stall = q_full;

   // request decode and stream phase tracking
   av1sw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_action   (req_action),
      .in_value    (req_value),
      .in_size_arg (req_size_arg),
      .q_full      (q_full),
      .push        (q_push),
      .push_pkt    (q_in_pkt)
   );

   // decoupling queue
   av1sw_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_pkt (q_in_pkt),
      .pop      (q_pop),
      .pop_pkt  (q_out_pkt),
      .full     (q_full),
      .empty    (q_empty)
   );

   // byte packing and result output
   av1sw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pkt        (q_out_pkt),
      .q_empty    (q_empty),
      .pop        (q_pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_last_of_item),
      .out_status (rsp_status)
   );

endmodule

// File: rtl/av1sw_front.sv
// ---------------------------------------------------------------------------
// av1sw_front
// Front end: decodes each request into a left-aligned bit packet, checks its
// arguments and tracks the byte phase and sticky error for the whole stream.
// ---------------------------------------------------------------------------
module av1sw_front
   import av1sw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [2:0]           in_action,
   input  logic [VALUE_W-1:0]   in_value,
   input  logic [SIZE_W-1:0]    in_size_arg,
   input  logic                 q_full,
   output logic                 push,
   output pkt_type              push_pkt
);

   // Index of the highest set bit (0 when none)
   function automatic logic [4:0] msb_idx32(input logic [31:0] x);
      logic [4:0] idx;
      idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   logic [2:0]          bc_ff, bc_in;
   logic                err_ff, err_in;

   logic                accept;
   logic [31:0]         v32;
   logic [32:0]         uvlc_val;
   logic [4:0]          uvlc_lz;
   logic [5:0]          ns_w;
   logic [32:0]         ns_pow;
   logic [32:0]         ns_m;
   logic [33:0]         ns_enc;
   logic                ns_lt;
   logic [VALUE_W-1:0]  le_swap;
   logic [LEN_W-1:0]    le_len;
   logic [2:0]          align_len;
   logic [3:0]          trail_len;

   logic                arg_err;
   logic                is_le;
   logic [LEN_W-1:0]    len;
   logic [VALUE_W-1:0]  rbits;
   logic [LEN_W-1:0]    sh_amt;
   logic [VALUE_W-1:0]  left_bits;

   assign accept = in_valid && !q_full;
   assign v32    = in_value[31:0];

   // uvlc: value+1 written with lz leading zeros
   assign uvlc_val = {1'b0, v32} + 33'd1;
   assign uvlc_lz  = msb_idx32(uvlc_val[31:0]);

   // ns(n): w bits of n, m = 2^w - n
   assign ns_w   = {1'b0, msb_idx32(in_size_arg)} + 6'd1;
   assign ns_pow = 33'd1 << ns_w;
   assign ns_m   = ns_pow - {1'b0, in_size_arg};
   assign ns_lt  = ({1'b0, v32} < ns_m);
   assign ns_enc = {2'b00, v32} + {1'b0, ns_m};

   // le(n): bytes go out low byte first
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         le_swap[63-8*i -: 8] = in_value[8*i +: 8];
      end
   end
   assign le_len = {in_size_arg[3:0], 3'b000};

   // padding lengths from the current byte phase
   assign align_len = 3'd0 - bc_ff;
   assign trail_len = 4'd8 - {1'b0, bc_ff};

   // decode
   always_comb begin
      arg_err = 1'b0;
      is_le   = 1'b0;
      len     = '0;
      rbits   = '0;
      case (act_type'(in_action))
         ACT_F: begin
            arg_err = (in_size_arg == '0) || (in_size_arg > 32'd64);
            len     = in_size_arg[LEN_W-1:0];
            rbits   = in_value;
         end
         ACT_UVLC: begin
            arg_err = uvlc_val[32];
            len     = {1'b0, uvlc_lz, 1'b1};
            rbits   = {31'b0, uvlc_val};
         end
         ACT_NS: begin
            arg_err = (in_size_arg == '0);
            if (in_size_arg == 32'd1) begin
               len = '0;
            end else if (ns_lt) begin
               len   = {1'b0, ns_w - 6'd1};
               rbits = {32'b0, v32};
            end else begin
               len   = {1'b0, ns_w};
               rbits = {30'b0, ns_enc};
            end
         end
         ACT_SU: begin
            arg_err = (in_size_arg == '0) || (in_size_arg > 32'd32);
            len     = in_size_arg[LEN_W-1:0];
            rbits   = {32'b0, v32};
         end
         ACT_LE: begin
            arg_err = (in_size_arg == '0) || (in_size_arg > 32'd8) || (bc_ff != 3'd0);
            is_le   = 1'b1;
            len     = le_len;
         end
         ACT_ALIGN: begin
            len = {4'b0, align_len};
         end
         ACT_TRAIL: begin
            len   = {3'b0, trail_len};
            rbits = {56'b0, 8'h80 >> bc_ff};
         end
         default: begin
            len = '0;
         end
      endcase
   end

   // left align, dropping bits above len
   assign sh_amt    = 7'd64 - len;
   assign left_bits = is_le ? (le_swap & ~({VALUE_W{1'b1}} >> len))
                            : (rbits << sh_amt);

   // packet and stream state update
   always_comb begin
      push          = 1'b0;
      push_pkt.kind = PKT_BITS;
      push_pkt.len  = len;
      push_pkt.bits = left_bits;
      bc_in         = bc_ff;
      err_in        = err_ff;
      if (accept) begin
         if (act_type'(in_action) == ACT_RESTART) begin
            push          = 1'b1;
            push_pkt.kind = PKT_RESTART;
            bc_in         = 3'd0;
            err_in        = 1'b0;
         end else if (!err_ff) begin
            if (arg_err) begin
               push          = 1'b1;
               push_pkt.kind = PKT_ERROR;
               err_in        = 1'b1;
            end else if (len != '0) begin
               push  = 1'b1;
               bc_in = bc_ff + len[2:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff  <= '0;
         err_ff <= 1'b0;
      end else begin
         bc_ff  <= bc_in;
         err_ff <= err_in;
      end
   end

endmodule

// File: rtl/av1sw_fifo.sv
// ---------------------------------------------------------------------------
// av1sw_fifo
// Small packet queue between the front end and the back end.
// ---------------------------------------------------------------------------
module av1sw_fifo
   import av1sw_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pkt_type  push_pkt,
   input  logic     pop,
   output pkt_type  pop_pkt,
   output logic     full,
   output logic     empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pkt_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_pkt = mem_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_pkt;
      end
   end

endmodule

// File: rtl/av1sw_back.sv
// ---------------------------------------------------------------------------
// av1sw_back
// Back end: merges packets into the bit accumulator and emits one byte (or
// one error result) per unstalled cycle via a registered output stage.
// ---------------------------------------------------------------------------
module av1sw_back
   import av1sw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pkt_type      pkt,
   input  logic         q_empty,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_stall,
   output logic [7:0]   out_byte,
   output logic         out_last,
   output logic         out_status
);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               ov_ff, ov_in;
   logic [7:0]         byte_ff;
   logic               last_ff;
   logic               status_ff;

   logic               slot_free;
   logic [ACC_W-1:0]   merged_acc;
   logic [CNT_W-1:0]   merged_cnt;
   logic               emit;
   logic [7:0]         e_byte;
   logic               e_last;
   logic               e_status;

   assign slot_free = !ov_ff || !out_stall;

   // new packet placed right after the pending bits
   assign merged_acc = acc_ff | ({pkt.bits, 8'h00} >> cnt_ff[2:0]);
   assign merged_cnt = cnt_ff + pkt.len;

   // emit / merge control
   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      e_byte   = acc_ff[ACC_W-1 -: 8];
      e_last   = 1'b0;
      e_status = 1'b0;
      if (cnt_ff >= 7'd8) begin
         // drain the remaining whole bytes of the current request
         if (slot_free) begin
            emit   = 1'b1;
            e_last = (cnt_ff < 7'd16);
            acc_in = acc_ff << 8;
            cnt_in = cnt_ff - 7'd8;
         end
      end else if (!q_empty) begin
         case (pkt.kind)
            PKT_BITS: begin
               if (merged_cnt < 7'd8) begin
                  pop    = 1'b1;
                  acc_in = merged_acc;
                  cnt_in = merged_cnt;
               end else if (slot_free) begin
                  pop    = 1'b1;
                  emit   = 1'b1;
                  e_byte = merged_acc[ACC_W-1 -: 8];
                  e_last = (merged_cnt < 7'd16);
                  acc_in = merged_acc << 8;
                  cnt_in = merged_cnt - 7'd8;
               end
            end
            PKT_ERROR: begin
               if (slot_free) begin
                  pop      = 1'b1;
                  emit     = 1'b1;
                  e_byte   = 8'h00;
                  e_last   = 1'b1;
                  e_status = 1'b1;
               end
            end
            PKT_RESTART: begin
               pop    = 1'b1;
               acc_in = '0;
               cnt_in = '0;
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   assign ov_in = slot_free ? emit : ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff   <= e_byte;
         last_ff   <= e_last;
         status_ff <= e_status;
      end
   end

   assign out_valid  = ov_ff;
   assign out_byte   = byte_ff;
   assign out_last   = last_ff;
   assign out_status = status_ff;

endmodule

// File: rtl/av1sw_checker.sv
// ---------------------------------------------------------------------------
// av1sw_checker
// Port-level checks for the syntax-element bit writer, bound to the top.
// ---------------------------------------------------------------------------
module av1sw_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_stall,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic [7:0]    rsp_out_byte,
   input  logic          rsp_last_of_item,
   input  logic          rsp_status
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_of_item) && $stable(rsp_status))
      else $error("stalled result changed");

   // an error result carries no byte and closes its request
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last_of_item && (rsp_out_byte == 8'h00))
      else $error("malformed error result");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // queue is empty after reset, so requests are taken
   a_req_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("request stalled after reset");

endmodule

bind av1_syntax_element_bit_writer av1sw_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_last_of_item (rsp_last_of_item),
   .rsp_status       (rsp_status)
);
